/* hdl/sync_framed_command_deframer_unit_assert.svh */
// Assertion macros for the framed command deframer.
`ifndef SYNC_FRAMED_COMMAND_DEFRAMER_UNIT_ASSERT_SVH
`define SYNC_FRAMED_COMMAND_DEFRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SFCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcd assertion failed");

`define SFCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcd assertion failed");

`else

`define SFCD_ASSERT_SAME(label, ante, cons)

`define SFCD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/sfcd_pkg.sv */
// Package with the phase codes and sync constants of the framed command deframer.
package sfcd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAC;
    localparam logic [7:0] SYNC_SECOND = 8'hBE;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_UNIT    = 4'd2,
        PH_CMD     = 4'd3,
        PH_ARG1_HI = 4'd4,
        PH_ARG1_LO = 4'd5,
        PH_ARG2_HI = 4'd6,
        PH_ARG2_LO = 4'd7,
        PH_SUM_HI  = 4'd8,
        PH_SUM_LO  = 4'd9
    } phase_t;

endpackage

/* hdl/sync_framed_command_deframer_unit.sv */
// Framed command deframer: parses ten-byte sync-framed command frames from a byte stream.
//
// Takes one received byte per cycle on the rx request channel. A frame is
// 0xAC, 0xBE, unit id, command, arg1 (hi, lo), arg2 (hi, lo), checksum (hi, lo).
// A wrong sync byte drops back to hunting without rechecking that byte. The
// last checksum byte produces one frame request with the fields, the checksum
// match flag and the good/bad frame counters after this frame (wrap at 2^32).
// Each byte passes an input register, then the parser with a running 16-bit
// checksum adder into the result register: the frame request is valid in the
// cycle after its last byte is parsed, one byte per cycle sustained but for rx_stall.
// rx_stall is raised only when a completing byte waits on a stalled, still
// occupied result register.
`include "sync_framed_command_deframer_unit_assert.svh"

module sync_framed_command_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        frame_valid,
    input  logic        frame_stall,
    output logic [7:0]  unit_id,
    output logic [7:0]  command,
    output logic [15:0] first_arg,
    output logic [15:0] second_arg,
    output logic        sum_ok,
    output logic [31:0] good_frames,
    output logic [31:0] bad_frames
);
    import sfcd_pkg::*;

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_unit_reg, held_unit_next;
    logic [7:0]  held_command_reg, held_command_next;
    logic [15:0] held_first_reg, held_first_next;
    logic [15:0] held_second_reg, held_second_next;
    logic [7:0]  sum_high_reg, sum_high_next;
    logic [15:0] sum_acc_reg, sum_acc_next;
    logic [31:0] good_total_reg, good_total_next;
    logic [31:0] bad_total_reg, bad_total_next;

    logic        frame_valid_reg, frame_valid_next;
    logic [7:0]  unit_id_reg;
    logic [7:0]  command_reg;
    logic [15:0] first_arg_reg;
    logic [15:0] second_arg_reg;
    logic        sum_ok_reg;
    logic [31:0] good_frames_reg;
    logic [31:0] bad_frames_reg;

    logic        last_byte;
    logic        advance;
    logic        finish;
    logic        match;
    logic [31:0] frame_total;

    assign last_byte = (phase_reg == PH_SUM_LO);
    assign advance   = byte_valid_reg && (!last_byte || !frame_valid_reg || !frame_stall);
    assign finish    = advance && last_byte;
    assign match     = ({sum_high_reg, byte_reg} == sum_acc_reg);
    assign rx_stall  = byte_valid_reg && !advance;
    assign frame_total = good_total_reg + bad_total_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            byte_reg       <= 8'd0;
        end
        else if (!rx_stall)
        begin
            byte_valid_reg <= rx_valid;
            byte_reg       <= rx_byte;
        end
    end

    // parser state
    always_comb
    begin
        phase_next        = phase_reg;
        held_unit_next    = held_unit_reg;
        held_command_next = held_command_reg;
        held_first_next   = held_first_reg;
        held_second_next  = held_second_reg;
        sum_high_next     = sum_high_reg;
        sum_acc_next      = sum_acc_reg;
        good_total_next   = good_total_reg;
        bad_total_next    = bad_total_reg;
        if (advance)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    phase_next = (byte_reg == SYNC_SECOND) ? PH_UNIT : PH_HUNT;
                end
                PH_UNIT:
                begin
                    held_unit_next = byte_reg;
                    sum_acc_next   = {8'd0, byte_reg};
                    phase_next     = PH_CMD;
                end
                PH_CMD:
                begin
                    held_command_next = byte_reg;
                    sum_acc_next      = sum_acc_reg + {8'd0, byte_reg};
                    phase_next        = PH_ARG1_HI;
                end
                PH_ARG1_HI:
                begin
                    held_first_next = {byte_reg, 8'd0};
                    phase_next      = PH_ARG1_LO;
                end
                PH_ARG1_LO:
                begin
                    held_first_next = {held_first_reg[15:8], byte_reg};
                    sum_acc_next    = sum_acc_reg + {held_first_reg[15:8], byte_reg};
                    phase_next      = PH_ARG2_HI;
                end
                PH_ARG2_HI:
                begin
                    held_second_next = {byte_reg, 8'd0};
                    phase_next       = PH_ARG2_LO;
                end
                PH_ARG2_LO:
                begin
                    held_second_next = {held_second_reg[15:8], byte_reg};
                    sum_acc_next     = sum_acc_reg + {held_second_reg[15:8], byte_reg};
                    phase_next       = PH_SUM_HI;
                end
                PH_SUM_HI:
                begin
                    sum_high_next = byte_reg;
                    phase_next    = PH_SUM_LO;
                end
                PH_SUM_LO:
                begin
                    if (match)
                    begin
                        good_total_next = good_total_reg + 32'd1;
                    end
                    else
                    begin
                        bad_total_next = bad_total_reg + 32'd1;
                    end
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = (byte_reg == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            held_unit_reg    <= 8'd0;
            held_command_reg <= 8'd0;
            held_first_reg   <= 16'd0;
            held_second_reg  <= 16'd0;
            sum_high_reg     <= 8'd0;
            sum_acc_reg      <= 16'd0;
            good_total_reg   <= 32'd0;
            bad_total_reg    <= 32'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            held_unit_reg    <= held_unit_next;
            held_command_reg <= held_command_next;
            held_first_reg   <= held_first_next;
            held_second_reg  <= held_second_next;
            sum_high_reg     <= sum_high_next;
            sum_acc_reg      <= sum_acc_next;
            good_total_reg   <= good_total_next;
            bad_total_reg    <= bad_total_next;
        end
    end

    // result register
    always_comb
    begin
        if (finish)
        begin
            frame_valid_next = 1'b1;
        end
        else
        begin
            frame_valid_next = frame_valid_reg && frame_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            unit_id_reg     <= held_unit_reg;
            command_reg     <= held_command_reg;
            first_arg_reg   <= held_first_reg;
            second_arg_reg  <= held_second_reg;
            sum_ok_reg      <= match;
            good_frames_reg <= good_total_next;
            bad_frames_reg  <= bad_total_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign unit_id     = unit_id_reg;
    assign command     = command_reg;
    assign first_arg   = first_arg_reg;
    assign second_arg  = second_arg_reg;
    assign sum_ok      = sum_ok_reg;
    assign good_frames = good_frames_reg;
    assign bad_frames  = bad_frames_reg;

    `SFCD_ASSERT_SAME(a_stall_needs_byte, rx_stall, byte_valid_reg && last_byte)
    `SFCD_ASSERT_NEXT(a_finish_counts, finish, frame_valid_reg && (frame_total == $past(frame_total) + 32'd1))
    `SFCD_ASSERT_NEXT(a_counters_hold, !finish, $stable(good_total_reg) && $stable(bad_total_reg))

endmodule
